// ===== src/fsac_pkg.sv =====
// Shared types and constants for the frame sum/add check validator.
`default_nettype none

package fsac_pkg;

    localparam int unsigned MAX_FRAME = 255;

    localparam logic [7:0] FUNC_ACK     = 8'h00;
    localparam logic [7:0] FUNC_REC_LO  = 8'hE0;
    localparam logic [7:0] FUNC_REC_HI  = 8'hE1;
    localparam logic [8:0] LEN_OVERHEAD = 9'd6;
    localparam logic [8:0] LEN_ACK_MIN  = 9'd9;

    localparam logic [1:0] REG_EXP_ID  = 2'd0;
    localparam logic [1:0] REG_EXP_SUM = 2'd1;
    localparam logic [1:0] REG_EXP_ADD = 2'd2;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_LEN_BAD  = 3'd2,
        ST_SUM_BAD  = 3'd3,
        ST_ADD_BAD  = 3'd4,
        ST_OVERFLOW = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_ACK    = 2'd1,
        ACT_RECORD = 2'd2
    } action_t;

    typedef struct packed {
        logic [7:0] exp_id;
        logic [7:0] exp_sum;
        logic [7:0] exp_add;
    } expect_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] add_check;
        logic [7:0] sum_check;
        logic [7:0] func_id;
        status_t    status;
    } result_t;

endpackage

`default_nettype wire

// ===== src/fsac_track.sv =====
// Per-frame running sums, header capture and end-of-frame checks.
`default_nettype none

module fsac_track
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             take,
    input  wire logic [7:0]       rx_byte,
    input  wire logic             frame_end,
    input  wire fsac_pkg::expect_t expect_cfg,
    output fsac_pkg::result_t     res
);

    logic [7:0] sum_reg, sum_next;
    logic [7:0] add_reg, add_next;
    logic [7:0] d0_reg, d0_next;
    logic [7:0] d1_reg, d1_next;
    logic [7:0] cnt_reg, cnt_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] func_reg, func_next;
    logic [2:0] match_reg, match_next;
    logic       ovf_reg, ovf_next;
    logic [8:0] frame_len;

    always_comb
    begin
        ovf_next   = ovf_reg | (cnt_reg >= 8'(fsac_pkg::MAX_FRAME));
        sum_next   = sum_reg;
        add_next   = add_reg;
        if (cnt_reg >= 8'd2)
        begin
            sum_next = sum_reg + d1_reg;
            add_next = add_reg + sum_next;
        end
        d1_next    = d0_reg;
        d0_next    = rx_byte;
        func_next  = func_reg;
        len_next   = len_reg;
        match_next = match_reg;
        case (cnt_reg)
            8'd2: func_next = rx_byte;
            8'd3: len_next  = rx_byte;
            8'd4: match_next[0] = match_reg[0] | (rx_byte == expect_cfg.exp_id);
            8'd5: match_next[1] = match_reg[1] | (rx_byte == expect_cfg.exp_sum);
            8'd6: match_next[2] = match_reg[2] | (rx_byte == expect_cfg.exp_add);
            default: ;
        endcase
        cnt_next  = (cnt_reg == 8'hFF) ? cnt_reg : cnt_reg + 8'd1;
        frame_len = {1'b0, cnt_reg} + 9'd1;
    end

    always_comb
    begin
        res.func_id   = func_next;
        res.sum_check = sum_next;
        res.add_check = add_next;
        if (ovf_next)
            res.status = fsac_pkg::ST_OVERFLOW;
        else if (frame_len < fsac_pkg::LEN_OVERHEAD)
            res.status = fsac_pkg::ST_SHORT;
        else if ({1'b0, len_next} != frame_len - fsac_pkg::LEN_OVERHEAD)
            res.status = fsac_pkg::ST_LEN_BAD;
        else if (sum_next != d1_next)
            res.status = fsac_pkg::ST_SUM_BAD;
        else if (add_next != d0_next)
            res.status = fsac_pkg::ST_ADD_BAD;
        else
            res.status = fsac_pkg::ST_OK;

        res.action = fsac_pkg::ACT_NONE;
        if (res.status == fsac_pkg::ST_OK)
        begin
            if (func_next == fsac_pkg::FUNC_ACK)
            begin
                if (frame_len >= fsac_pkg::LEN_ACK_MIN && match_next == 3'b111)
                    res.action = fsac_pkg::ACT_ACK;
            end
            else if (func_next == fsac_pkg::FUNC_REC_LO || func_next == fsac_pkg::FUNC_REC_HI)
                res.action = fsac_pkg::ACT_RECORD;
        end
    end

    // clear frame state on the last byte, advance otherwise
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            add_reg   <= '0;
            d0_reg    <= '0;
            d1_reg    <= '0;
            cnt_reg   <= '0;
            len_reg   <= '0;
            func_reg  <= '0;
            match_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (take)
        begin
            if (frame_end)
            begin
                sum_reg   <= '0;
                add_reg   <= '0;
                d0_reg    <= '0;
                d1_reg    <= '0;
                cnt_reg   <= '0;
                len_reg   <= '0;
                func_reg  <= '0;
                match_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                sum_reg   <= sum_next;
                add_reg   <= add_next;
                d0_reg    <= d0_next;
                d1_reg    <= d1_next;
                cnt_reg   <= cnt_next;
                len_reg   <= len_next;
                func_reg  <= func_next;
                match_reg <= match_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/fsac_out.sv =====
// Result register with valid/ready handshake towards the master side.
`default_nettype none

module fsac_out
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire fsac_pkg::result_t res,
    output logic                   space,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output fsac_pkg::result_t      out_res
);

    logic              valid_reg;
    fsac_pkg::result_t res_reg;

    assign space     = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (space)
            valid_reg <= load;
    end

    // hold the result while the downstream stalls
    always_ff @(posedge clk)
    begin
        if (space && load)
            res_reg <= res;
    end

endmodule

`default_nettype wire

// ===== src/frame_sum_add_check_validator_unit.sv =====
// Top level: frame sum/add check validator with stream ports and register writes.
// Result: registered, it appears on the master side in the cycle after the tlast byte is taken.
// Throughput: one byte per cycle; s_tready drops only while a result waits on m_tready.
// Reset: rst_n clears frame state, the result valid and the expected record to zero.
`default_nettype none

module frame_sum_add_check_validator_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        s_tlast,   // frame_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [2:0] status, [10:3] func_id, [18:11] sum_check,
                                        // [26:19] add_check, [28:27] action, [31:29] zero
);

    fsac_pkg::expect_t expect_reg;
    fsac_pkg::result_t res;
    fsac_pkg::result_t out_res;
    logic              space;
    logic              take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            expect_reg <= '0;
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                fsac_pkg::REG_EXP_ID:  expect_reg.exp_id  <= cfg_data;
                fsac_pkg::REG_EXP_SUM: expect_reg.exp_sum <= cfg_data;
                fsac_pkg::REG_EXP_ADD: expect_reg.exp_add <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_tready = space;
    assign take     = s_tvalid && space;

    fsac_track u_track
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .rx_byte    (s_tdata),
        .frame_end  (s_tlast),
        .expect_cfg (expect_reg),
        .res        (res)
    );

    fsac_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take && s_tlast),
        .res       (res),
        .space     (space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {3'b000, out_res};

`ifndef SYNTH
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("no result after last byte");

    a_mid_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tlast |=> !m_tvalid)
        else $error("result without last byte");

    a_action_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2:0] != fsac_pkg::ST_OK |-> m_tdata[28:27] == fsac_pkg::ACT_NONE)
        else $error("action on failed frame");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("stalled with empty result register");
`endif

endmodule

`default_nettype wire
